// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PRQ_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("prq assertion failed");

// Consequent checked in the cycle after the antecedent.
`define PRQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("prq assertion failed");

`endif

// ===== rtl/prq_pkg.sv =====
// Package: constants, codes and types of the run queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
package prq_pkg;
  localparam int MAX_PROCS = 16;
  localparam int PID_W     = 4;
  localparam int PID_N     = 2 ** PID_W;
  localparam int GOOD_W    = 16;
  localparam int SLICE_W   = 8;
  localparam int QCNT_W    = 5;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam logic [SLICE_W-1:0] MAX_SLICE_RST = SLICE_W'(5);

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_PICK = 2'd2,
    KIND_TICK = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e                     kind;
    logic [PID_W-1:0]          pid;
    logic signed [GOOD_W-1:0]  goodness;
    logic [SLICE_W-1:0]        slice_in;
  } item_t;

  typedef struct packed {
    logic                found;
    logic [PID_W-1:0]    chosen_pid;
    logic [SLICE_W-1:0]  slice_out;
    logic                resched;
    logic                fault;
    logic [QCNT_W-1:0]   queued_count;
  } res_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;
endpackage
`default_nettype wire

// ===== rtl/priority_run_queue_scheduler.sv =====
// Top level: stream ports, APB register and output register of the scheduler.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser: kind; tdata: pid, goodness, slice_in
//  m_axis    out  tvalid/tready          tdata: found .. queued_count
//  apb       in   psel/penable/pready    max_slice at byte address 0
//
// Enqueue, tick and a dequeue of an absent pid go from accept through execute to done.
// Dequeue of a present pid and pick also pass the scan state, which walks the queue
// through the single read port of the order RAM and the one shared comparator.
// The input is not ready from accept until the result moves to the output register.
// Reset clears the membership bits and the count; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module priority_run_queue_scheduler import prq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [3:0] pid, [19:4] goodness, [27:20] slice_in
  input  wire logic [31:0]       s_axis_tdata_i,
  // [1:0] kind
  input  wire logic [1:0]        s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // [0] found, [4:1] chosen_pid, [12:5] slice_out, [13] resched, [14] fault,
  // [19:15] queued_count
  output logic [23:0]            m_axis_tdata_o,
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [APB_AW-1:0] paddr_i,
  input  wire logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0]      prdata_o,
  output logic                   pready_o
);
  logic [SLICE_W-1:0] max_slice_q;
  logic               m_valid_q;
  res_t               m_res_q;
  item_t              item;
  res_t               core_res;
  logic               core_res_valid;
  logic               core_res_ready;
  logic               reg_sel;

  assign pready_o = 1'b1;
  assign reg_sel  = !paddr_i[2];
  assign prdata_o = reg_sel ? APB_DW'(max_slice_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_slice_q <= MAX_SLICE_RST;
    end else if (psel_i && penable_i && pwrite_i && pready_o && reg_sel) begin
      max_slice_q <= pwdata_i[SLICE_W-1:0];
    end
  end

  assign item.kind     = kind_e'(s_axis_tuser_i);
  assign item.pid      = s_axis_tdata_i[3:0];
  assign item.goodness = s_axis_tdata_i[19:4];
  assign item.slice_in = s_axis_tdata_i[27:20];

  prq_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid_i),
    .item_ready_o (s_axis_tready_o),
    .item_i       (item),
    .max_slice_i  (max_slice_q),
    .res_valid_o  (core_res_valid),
    .res_ready_i  (core_res_ready),
    .res_o        (core_res)
  );

  assign core_res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (core_res_ready) begin
      m_valid_q <= core_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res_ready && core_res_valid) begin
      m_res_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0, m_res_q.queued_count, m_res_q.fault, m_res_q.resched,
                            m_res_q.slice_out, m_res_q.chosen_pid, m_res_q.found};
endmodule
`default_nettype wire

// ===== rtl/prq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/prq_cmp.sv =====
// Shared signed comparator used by the pick and dequeue scans.
`timescale 1ns / 1ps
`default_nettype none
module prq_cmp import prq_pkg::*; (
  input  wire logic signed [GOOD_W-1:0] a_i,
  input  wire logic signed [GOOD_W-1:0] b_i,
  output cmp_res_t                      res_o
);
  assign res_o.gt = (a_i > b_i);
  assign res_o.eq = (a_i == b_i);
endmodule
`default_nettype wire

// ===== rtl/prq_core.sv =====
// Sequencer, queue state and scan pipeline of the run queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
module prq_core import prq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  input  wire item_t              item_i,
  input  wire logic [SLICE_W-1:0] max_slice_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output res_t                    res_o
);
  state_e state_q, state_d;
  item_t  item_q, item_d;
  res_t   res_q, res_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic [CNT_W-1:0] wr_q, wr_d;
  logic [PID_N-1:0] member_q, member_d;
  logic             s1_v_q, s1_v_d;
  logic             s2_v_q, s2_v_d;
  logic [PID_W-1:0] s2_pid_q, s2_pid_d;
  logic signed [GOOD_W-1:0] best_q, best_d;
  logic             found_q, found_d;
  logic [PID_W-1:0] chosen_q, chosen_d;

  logic               ord_we;
  logic [IDX_W-1:0]   ord_waddr, ord_raddr;
  logic [PID_W-1:0]   ord_wdata, ord_rdata;
  logic               good_we;
  logic [PID_W-1:0]   good_waddr, good_raddr;
  logic [GOOD_W-1:0]  good_wdata, good_rdata;
  logic signed [GOOD_W-1:0] cmp_a, cmp_b;
  cmp_res_t           cmp_res;
  logic [SLICE_W-1:0] tick_slice;

  prq_ram #(.WIDTH(PID_W), .DEPTH(MAX_PROCS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  prq_ram #(.WIDTH(GOOD_W), .DEPTH(PID_N)) u_good_ram (
    .clk_i   (clk_i),
    .we_i    (good_we),
    .waddr_i (good_waddr),
    .wdata_i (good_wdata),
    .raddr_i (good_raddr),
    .rdata_o (good_rdata)
  );

  prq_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  assign item_ready_o = (state_q == ST_IDLE);
  assign res_valid_o  = (state_q == ST_DONE);
  assign res_o        = res_q;

  always_comb begin
    if (item_q.kind == KIND_PICK) begin
      cmp_a = good_rdata;
      cmp_b = best_q;
    end else begin
      cmp_a = GOOD_W'(ord_rdata);
      cmp_b = GOOD_W'(item_q.pid);
    end
  end

  assign tick_slice = (item_q.slice_in != '0) ? item_q.slice_in - SLICE_W'(1)
                                              : item_q.slice_in;

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    issue_d    = issue_q;
    wr_d       = wr_q;
    member_d   = member_q;
    s1_v_d     = 1'b0;
    s2_v_d     = 1'b0;
    s2_pid_d   = s2_pid_q;
    best_d     = best_q;
    found_d    = found_q;
    chosen_d   = chosen_q;
    ord_we     = 1'b0;
    ord_waddr  = cnt_q[IDX_W-1:0];
    ord_wdata  = item_q.pid;
    ord_raddr  = issue_q[IDX_W-1:0];
    good_we    = 1'b0;
    good_waddr = item_q.pid;
    good_wdata = item_q.goodness;
    good_raddr = ord_rdata;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d              = '0;
        res_d.queued_count = QCNT_W'(cnt_q);
        issue_d            = '0;
        wr_d               = '0;
        found_d            = 1'b0;
        chosen_d           = '0;
        best_d             = '0;
        state_d            = ST_DONE;
        case (item_q.kind)
          KIND_ENQ: begin
            if (member_q[item_q.pid] || (cnt_q >= CNT_W'(MAX_PROCS))) begin
              res_d.fault = 1'b1;
            end else begin
              ord_we                = 1'b1;
              good_we               = 1'b1;
              member_d[item_q.pid]  = 1'b1;
              cnt_d                 = cnt_q + CNT_W'(1);
              res_d.queued_count    = QCNT_W'(cnt_q + CNT_W'(1));
              if ((item_q.slice_in == '0) || (item_q.slice_in > max_slice_i)) begin
                res_d.slice_out = max_slice_i;
              end else begin
                res_d.slice_out = item_q.slice_in;
              end
            end
          end
          KIND_DEQ: begin
            if (!member_q[item_q.pid]) begin
              res_d.fault = 1'b1;
            end else begin
              state_d = ST_SCAN;
            end
          end
          KIND_PICK: begin
            state_d = ST_SCAN;
          end
          default: begin
            res_d.slice_out = tick_slice;
            res_d.resched   = (tick_slice == '0);
          end
        endcase
      end
      ST_SCAN: begin
        if (issue_q < cnt_q) begin
          issue_d = issue_q + CNT_W'(1);
          s1_v_d  = 1'b1;
        end
        if (s1_v_q) begin
          if (item_q.kind == KIND_PICK) begin
            s2_v_d   = 1'b1;
            s2_pid_d = ord_rdata;
          end else if (!cmp_res.eq) begin
            ord_we    = 1'b1;
            ord_waddr = wr_q[IDX_W-1:0];
            ord_wdata = ord_rdata;
            wr_d      = wr_q + CNT_W'(1);
          end
        end
        if (s2_v_q && (!found_q || cmp_res.gt)) begin
          found_d  = 1'b1;
          best_d   = good_rdata;
          chosen_d = s2_pid_q;
        end
        if ((issue_q == cnt_q) && !s1_v_q && !s2_v_q) begin
          state_d = ST_DONE;
          if (item_q.kind == KIND_PICK) begin
            res_d.found      = found_q;
            res_d.chosen_pid = chosen_q;
          end else begin
            cnt_d                = wr_q;
            member_d[item_q.pid] = 1'b0;
            res_d.queued_count   = QCNT_W'(wr_q);
          end
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      member_q <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      member_q <= member_d;
      s1_v_q   <= s1_v_d;
      s2_v_q   <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    res_q    <= res_d;
    issue_q  <= issue_d;
    wr_q     <= wr_d;
    s2_pid_q <= s2_pid_d;
    best_q   <= best_d;
    found_q  <= found_d;
    chosen_q <= chosen_d;
  end
endmodule
`default_nettype wire

// ===== rtl/prq_checker.sv =====
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module prq_checker import prq_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid_i,
  input wire logic              s_axis_tready_o,
  input wire logic              m_axis_tvalid_o,
  input wire logic              m_axis_tready_i,
  input wire logic [23:0]       m_axis_tdata_o
);
  `PRQ_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `PRQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `PRQ_ASSERT(a_count_range, clk_i, rst_ni, !m_axis_tvalid_o || (m_axis_tdata_o[19:15] <= QCNT_W'(PID_N)))
  `PRQ_ASSERT(a_found_clean, clk_i, rst_ni, !(m_axis_tvalid_o && m_axis_tdata_o[0]) || (!m_axis_tdata_o[14] && !m_axis_tdata_o[13]))
endmodule

bind priority_run_queue_scheduler prq_checker u_prq_checker (.*);
`default_nettype wire

// ===== tb/tb_priority_run_queue_scheduler.sv =====
// Self-checking testbench: random and directed requests against a built-in scheduler predictor.
`timescale 1ns / 1ps
module tb_priority_run_queue_scheduler;
  import prq_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_LEN    = 400;
  localparam int DRAIN_WAIT  = 40;
  localparam logic [APB_AW-1:0] REG_MAX_SLICE = '0;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_valid = 1'b0;
  logic              s_ready;
  logic [31:0]       s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [23:0]       m_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  priority_run_queue_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always #5 clk_i = ~clk_i;

  // request source and expected results
  item_t request_q [$];
  res_t  sched_expect_q [$];
  int    mismatches = 0;
  bit    quiet = 1'b0;
  int    hold_ask = 0;
  int    hold_done = 0;
  int    hold_cnt = 0;
  logic  long_hold;

  // predictor state
  logic [PID_W-1:0]         rq_order [MAX_PROCS];
  logic                     rq_member [PID_N];
  logic signed [GOOD_W-1:0] rq_good [PID_N];
  int                       rq_count = 0;
  logic [SLICE_W-1:0]       slice_limit = MAX_SLICE_RST;

  // generator shadow of membership
  bit [PID_N-1:0] gen_member = '0;
  int             gen_count = 0;
  int             gen_total = 0;

  initial begin
    for (int i = 0; i < PID_N; i++) begin
      rq_member[i] = 1'b0;
      rq_good[i]   = '0;
    end
    for (int i = 0; i < MAX_PROCS; i++) rq_order[i] = '0;
  end

  task automatic predict_request(input item_t it, output res_t r);
    logic signed [GOOD_W-1:0] best;
    logic [PID_W-1:0] p;
    int w;
    r = '0;
    best = '0;
    w = 0;
    case (it.kind)
      KIND_ENQ: begin
        if (rq_member[it.pid] || rq_count >= MAX_PROCS) begin
          r.fault = 1'b1;
        end else begin
          rq_order[rq_count] = it.pid;
          rq_count++;
          rq_member[it.pid] = 1'b1;
          rq_good[it.pid] = it.goodness;
          r.slice_out = (it.slice_in == 0 || it.slice_in > slice_limit) ? slice_limit
                                                                         : it.slice_in;
        end
      end
      KIND_DEQ: begin
        if (!rq_member[it.pid]) begin
          r.fault = 1'b1;
        end else begin
          for (int i = 0; i < rq_count; i++) begin
            if (rq_order[i] != it.pid) begin
              rq_order[w] = rq_order[i];
              w++;
            end
          end
          rq_count = w;
          rq_member[it.pid] = 1'b0;
        end
      end
      KIND_PICK: begin
        for (int i = 0; i < rq_count; i++) begin
          p = rq_order[i];
          if (!r.found || rq_good[p] > best) begin
            r.found = 1'b1;
            best = rq_good[p];
            r.chosen_pid = p;
          end
        end
      end
      default: begin
        r.slice_out = (it.slice_in > 0) ? it.slice_in - 8'd1 : 8'd0;
        r.resched = (r.slice_out == 0);
      end
    endcase
    r.queued_count = rq_count[QCNT_W-1:0];
  endtask

  // driver
  int    send_gap = 0;
  item_t cur_req;

  always @(posedge clk_i) begin
    logic nxt_valid;
    res_t r;
    nxt_valid = s_valid;
    if (s_valid && s_ready) begin
      predict_request(cur_req, r);
      sched_expect_q.push_back(r);
    end
    if (!s_valid || s_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        nxt_valid = 1'b0;
      end else if (request_q.size() > 0) begin
        cur_req = request_q.pop_front();
        s_tdata <= {4'b0, cur_req.slice_in, cur_req.goodness, cur_req.pid};
        s_tuser <= cur_req.kind;
        nxt_valid = 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
      end else begin
        nxt_valid = 1'b0;
      end
    end
    s_valid <= nxt_valid;
  end

  // long receiver hold-off
  assign long_hold = (hold_done != hold_ask);

  always @(posedge clk_i) begin
    if (long_hold) begin
      if (hold_cnt == HOLD_LEN) begin
        hold_cnt  <= 0;
        hold_done <= hold_ask;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  // monitor
  int rx_stall = 0;

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    logic nxt_ready;
    if (m_valid && m_ready) begin
      got.found        = m_tdata[0];
      got.chosen_pid   = m_tdata[4:1];
      got.slice_out    = m_tdata[12:5];
      got.resched      = m_tdata[13];
      got.fault        = m_tdata[14];
      got.queued_count = m_tdata[19:15];
      if (sched_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %h", m_tdata);
      end else begin
        want = sched_expect_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected found=%0d pid=%0d slice=%0d resched=%0d ",
                      "fault=%0d count=%0d, got found=%0d pid=%0d slice=%0d resched=%0d ",
                      "fault=%0d count=%0d"},
                     want.found, want.chosen_pid, want.slice_out, want.resched,
                     want.fault, want.queued_count, got.found, got.chosen_pid,
                     got.slice_out, got.resched, got.fault, got.queued_count);
        end
      end
    end
    if (long_hold) begin
      nxt_ready = 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = 1'b1;
      if (!quiet && $urandom_range(0, 6) == 0) rx_stall = $urandom_range(1, 11);
    end
    m_ready <= nxt_ready;
  end

  // stimulus helpers
  task automatic push_request(input kind_e k, input logic [PID_W-1:0] p,
                              input logic signed [GOOD_W-1:0] g,
                              input logic [SLICE_W-1:0] s);
    item_t it;
    it.kind     = k;
    it.pid      = p;
    it.goodness = g;
    it.slice_in = s;
    request_q.push_back(it);
    gen_total++;
    if (k == KIND_ENQ && !gen_member[p] && gen_count < MAX_PROCS) begin
      gen_member[p] = 1'b1;
      gen_count++;
    end else if (k == KIND_DEQ && gen_member[p]) begin
      gen_member[p] = 1'b0;
      gen_count--;
    end
  endtask

  function automatic logic [PID_W-1:0] rand_pid(input bit present);
    logic [PID_W-1:0] cand [$];
    for (int i = 0; i < PID_N; i++)
      if (gen_member[i] == present) cand.push_back(PID_W'(i));
    if (cand.size() == 0) return PID_W'($urandom_range(0, PID_N - 1));
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic logic signed [GOOD_W-1:0] rand_good();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return GOOD_W'($urandom_range(0, 2)) - 16'd1;
      default: return GOOD_W'($urandom);
    endcase
  endfunction

  function automatic logic [SLICE_W-1:0] rand_slice();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return slice_limit;
      3:       return slice_limit + 8'd1;
      4:       return 8'd1;
      default: return SLICE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PID_W-1:0] any_pid();
    return PID_W'($urandom_range(0, PID_N - 1));
  endfunction

  task automatic gen_random(input int n);
    int target;
    int r;
    target = gen_total + n;
    while (gen_total < target) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // fill the queue, then overflow it
        while (gen_count < MAX_PROCS)
          push_request(KIND_ENQ, rand_pid(1'b0), rand_good(), rand_slice());
        push_request(KIND_ENQ, any_pid(), rand_good(), rand_slice());
        push_request(KIND_PICK, any_pid(), rand_good(), rand_slice());
      end else if (r < 38) begin
        push_request(KIND_ENQ, ($urandom_range(0, 9) == 0) ? any_pid() : rand_pid(1'b0),
                     rand_good(), rand_slice());
      end else if (r < 63) begin
        push_request(KIND_DEQ, ($urandom_range(0, 9) == 0) ? any_pid() : rand_pid(1'b1),
                     rand_good(), rand_slice());
      end else if (r < 82) begin
        push_request(KIND_PICK, any_pid(), rand_good(), rand_slice());
      end else begin
        push_request(KIND_TICK, any_pid(), rand_good(), rand_slice());
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || s_valid || sched_expect_q.size() != 0);
  endtask

  task automatic write_max_slice(input logic [SLICE_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_SLICE;
    pwdata  <= APB_DW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    slice_limit = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty queue, ticks, faults, clamps, ties, removal
    push_request(KIND_PICK, 4'd0, 16'sd0, 8'd0);
    push_request(KIND_TICK, 4'd2, 16'sd0, 8'd0);
    push_request(KIND_TICK, 4'd2, 16'sd0, 8'd1);
    push_request(KIND_TICK, 4'd15, 16'sh7fff, 8'd255);
    push_request(KIND_DEQ, 4'd3, 16'sd0, 8'd0);
    push_request(KIND_ENQ, 4'd0, 16'sh8000, 8'd0);
    push_request(KIND_ENQ, 4'd15, 16'sh7fff, 8'd255);
    push_request(KIND_ENQ, 4'd7, 16'sh7fff, 8'd3);
    push_request(KIND_ENQ, 4'd0, 16'sd100, 8'd2);
    push_request(KIND_PICK, 4'd9, 16'sd0, 8'd0);
    push_request(KIND_DEQ, 4'd15, 16'sd0, 8'd0);
    push_request(KIND_PICK, 4'd0, 16'sd0, 8'd0);
    push_request(KIND_ENQ, 4'd9, 16'sd5, 8'd5);
    push_request(KIND_ENQ, 4'd10, 16'sh7fff, 8'd6);
    push_request(KIND_DEQ, 4'd0, 16'sd0, 8'd0);
    push_request(KIND_PICK, 4'd0, 16'sd0, 8'd0);
    push_request(KIND_DEQ, 4'd7, 16'sd0, 8'd0);
    push_request(KIND_DEQ, 4'd7, 16'sd0, 8'd0);
    push_request(KIND_DEQ, 4'd10, 16'sd0, 8'd0);
    push_request(KIND_DEQ, 4'd9, 16'sd0, 8'd0);
    push_request(KIND_PICK, 4'd0, 16'sd0, 8'd0);
    wait_idle();

    write_max_slice(8'd255);
    gen_random(300);
    wait_idle();

    write_max_slice(8'd1);
    hold_ask++;
    gen_random(250);
    wait_idle();

    write_max_slice(8'd0);
    gen_random(100);
    wait_idle();

    write_max_slice(SLICE_W'($urandom_range(2, 254)));
    hold_ask++;
    gen_random(250);
    wait_idle();

    write_max_slice(SLICE_W'($urandom_range(1, 12)));
    quiet = 1'b1;
    gen_random(230);
    wait_idle();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && sched_expect_q.size() == 0) begin
      $display("tb_priority_run_queue_scheduler: done, clean");
    end else begin
      $display("tb_priority_run_queue_scheduler: done, errors");
    end
    $finish;
  end

  int cycles = 0;

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_priority_run_queue_scheduler: done, errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/prq_cmp.sv
rtl/prq_core.sv
rtl/priority_run_queue_scheduler.sv
rtl/prq_checker.sv
tb/tb_priority_run_queue_scheduler.sv
